/* design/fbl_pkg.sv */
`timescale 1ns / 1ps

package fbl_pkg;

	// stack geometry
	localparam int CACHE_DEPTH = 100;
	localparam int ADDR_W      = $clog2(CACHE_DEPTH);
	localparam int COUNT_W     = $clog2(CACHE_DEPTH + 1);
	localparam int BLK_W       = 16;

	typedef enum logic [1:0] {
		CMD_ALLOC  = 2'd0,
		CMD_FREE   = 2'd1,
		CMD_LOAD   = 2'd2,
		CMD_UNLOAD = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		STAT_OK      = 3'd0,
		STAT_REFILL  = 3'd1,
		STAT_NOSPACE = 3'd2,
		STAT_BAD     = 3'd3,
		STAT_SPILL   = 3'd4,
		STAT_BUSY    = 3'd5,
		STAT_XFER    = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		MODE_IDLE         = 2'd0,
		MODE_LOAD_COUNT   = 2'd1,
		MODE_LOAD_ENTRIES = 2'd2,
		MODE_UNLOAD       = 2'd3
	} mode_t;

	typedef enum logic {
		REG_INODE_AREA = 1'b0,
		REG_VOLUME     = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]       cmd;
		logic [BLK_W-1:0] word;
	} req_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [BLK_W-1:0] block_out;
		logic             last;
	} rsp_t;

endpackage

/* design/fbl_ram.sv */
`timescale 1ns / 1ps

module fbl_ram #(
	parameter int DEPTH = 100,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* design/free_block_list_cache.sv */
`timescale 1ns / 1ps

// Free block list cache: a stack of up to CACHE_DEPTH free block numbers held in a
// single-port-read synchronous memory. A command is taken when start is high and
// busy is low; its one result appears on rsp, marked by done, for exactly one cycle,
// and must be taken then. Free, load and the count word of an unload are answered
// without leaving the idle state, so the next command may follow at once. An allocate
// refused as busy or on an empty stack is also answered from the idle state. An
// allocate that pops waits in S_POP on the registered read of the stack memory and
// reads it again for each out-of-range entry it drops; an unload of a stack entry
// waits in S_UNLD on that read. The result shows up in the cycle after the last
// working cycle. Configuration writes are always ready.
module free_block_list_cache (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  fbl_pkg::req_t       req,
	output logic                done,
	output fbl_pkg::rsp_t       rsp,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [15:0]         cfg_data
);

	import fbl_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_POP  = 3'b010,
		S_UNLD = 3'b100
	} state_t;

	state_t             state_q, state_d;
	mode_t              mode_q, mode_d;
	logic [COUNT_W-1:0] count_q, count_d;
	logic [COUNT_W-1:0] idx_q, idx_d;
	logic [BLK_W-1:0]   pend_q, pend_d;
	logic [BLK_W-1:0]   inode_q, volume_q;
	logic               done_q, done_d;
	rsp_t               rsp_q, rsp_d;

	logic               wr_en, rd_en;
	logic [ADDR_W-1:0]  wr_addr, rd_addr;
	logic [BLK_W-1:0]   wr_data, rd_data;
	logic [BLK_W:0]     lo_bound;
	logic               accept;
	logic [COUNT_W-1:0] idx_inc;
	logic [COUNT_W-1:0] load_cnt;

	function automatic logic out_of_range(input logic [BLK_W-1:0] blk,
			input logic [BLK_W:0] lo, input logic [BLK_W-1:0] hi);
		return ({1'b0, blk} < lo) || (blk >= hi);
	endfunction

	fbl_ram #(.DEPTH(CACHE_DEPTH), .WIDTH(BLK_W)) u_stack (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign done      = done_q;
	assign rsp       = rsp_q;
	assign cfg_ready = 1'b1;
	assign lo_bound  = {1'b0, inode_q} + (BLK_W+1)'(2);
	assign idx_inc   = idx_q + COUNT_W'(1);
	assign load_cnt  = (req.word > BLK_W'(CACHE_DEPTH)) ? '0 : req.word[COUNT_W-1:0];

	// command decode and stack sequencing
	always_comb begin
		state_d = state_q;
		mode_d  = mode_q;
		count_d = count_q;
		idx_d   = idx_q;
		pend_d  = pend_q;
		done_d  = 1'b0;
		rsp_d   = '{status: STAT_OK, block_out: '0, last: 1'b0};
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		rd_en   = 1'b0;
		rd_addr = count_q[ADDR_W-1:0] - ADDR_W'(1);

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (cmd_t'(req.cmd))
						CMD_ALLOC: begin
							if (mode_q != MODE_IDLE) begin
								done_d       = 1'b1;
								rsp_d.status = STAT_BUSY;
							end else if (count_q == '0 || count_q > COUNT_W'(CACHE_DEPTH)) begin
								count_d      = '0;
								done_d       = 1'b1;
								rsp_d.status = STAT_NOSPACE;
							end else begin
								rd_en   = 1'b1;
								count_d = count_q - COUNT_W'(1);
								state_d = S_POP;
							end
						end
						CMD_FREE: begin
							done_d = 1'b1;
							if (mode_q != MODE_IDLE) begin
								rsp_d.status = STAT_BUSY;
							end else if (out_of_range(req.word, lo_bound, volume_q)) begin
								rsp_d.status = STAT_BAD;
							end else if (count_q >= COUNT_W'(CACHE_DEPTH)) begin
								mode_d          = MODE_UNLOAD;
								idx_d           = '0;
								pend_d          = req.word;
								rsp_d.status    = STAT_SPILL;
								rsp_d.block_out = req.word;
							end else begin
								wr_en   = 1'b1;
								wr_addr = count_q[ADDR_W-1:0];
								wr_data = req.word;
								count_d = count_q + COUNT_W'(1);
							end
						end
						CMD_LOAD: begin
							done_d = 1'b1;
							unique case (mode_q)
								MODE_LOAD_COUNT: begin
									rsp_d.status = STAT_XFER;
									count_d      = load_cnt;
									idx_d        = '0;
									if (load_cnt == '0) begin
										mode_d     = MODE_IDLE;
										rsp_d.last = 1'b1;
									end else begin
										mode_d = MODE_LOAD_ENTRIES;
									end
								end
								MODE_LOAD_ENTRIES: begin
									rsp_d.status = STAT_XFER;
									wr_en   = (idx_q < COUNT_W'(CACHE_DEPTH));
									wr_addr = idx_q[ADDR_W-1:0];
									wr_data = req.word;
									idx_d   = idx_inc;
									if (idx_inc >= count_q) begin
										mode_d     = MODE_IDLE;
										idx_d      = '0;
										rsp_d.last = 1'b1;
									end
								end
								default: begin
									rsp_d.status = STAT_BUSY;
								end
							endcase
						end
						CMD_UNLOAD: begin
							if (mode_q != MODE_UNLOAD) begin
								done_d       = 1'b1;
								rsp_d.status = STAT_BUSY;
							end else if (idx_q == '0) begin
								done_d          = 1'b1;
								rsp_d.status    = STAT_XFER;
								rsp_d.block_out = BLK_W'(count_q);
								idx_d           = idx_inc;
							end else begin
								rd_en   = 1'b1;
								rd_addr = idx_q[ADDR_W-1:0] - ADDR_W'(1);
								state_d = S_UNLD;
							end
						end
						default: ;
					endcase
				end
			end
			S_POP: begin
				if (rd_data == '0) begin
					// zero entry stays on the stack
					count_d      = count_q + COUNT_W'(1);
					done_d       = 1'b1;
					rsp_d.status = STAT_NOSPACE;
					state_d      = S_IDLE;
				end else if (out_of_range(rd_data, lo_bound, volume_q)) begin
					// drop the entry and pop again
					if (count_q == '0) begin
						done_d       = 1'b1;
						rsp_d.status = STAT_NOSPACE;
						state_d      = S_IDLE;
					end else begin
						rd_en   = 1'b1;
						count_d = count_q - COUNT_W'(1);
					end
				end else begin
					done_d          = 1'b1;
					rsp_d.block_out = rd_data;
					state_d         = S_IDLE;
					if (count_q == '0) begin
						mode_d       = MODE_LOAD_COUNT;
						idx_d        = '0;
						rsp_d.status = STAT_REFILL;
					end else begin
						rsp_d.status = STAT_OK;
					end
				end
			end
			S_UNLD: begin
				done_d          = 1'b1;
				rsp_d.status    = STAT_XFER;
				rsp_d.block_out = rd_data;
				state_d         = S_IDLE;
				if (idx_q >= COUNT_W'(CACHE_DEPTH)) begin
					// spill complete: push the freed block onto an empty stack
					wr_en      = 1'b1;
					wr_addr    = '0;
					wr_data    = pend_q;
					count_d    = COUNT_W'(1);
					mode_d     = MODE_IDLE;
					idx_d      = '0;
					rsp_d.last = 1'b1;
				end else begin
					idx_d = idx_inc;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q  <= MODE_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			pend_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			pend_q  <= pend_d;
			done_q  <= done_d;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		rsp_q <= rsp_d;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inode_q  <= '0;
			volume_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_INODE_AREA: inode_q  <= cfg_data;
				REG_VOLUME:     volume_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// checks
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobed while a transaction is still in progress");

	a_accept_answers: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (done || busy))
		else $error("accepted transaction neither answered nor in progress");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(CACHE_DEPTH))
		else $error("free count exceeds stack depth");

	a_load_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_LOAD_ENTRIES) |-> (count_q != '0 && idx_q < count_q))
		else $error("loading entries with no entries outstanding");

endmodule
